// File: rtl/drm_pkg.sv
// shared constants, state encoding and control structs for the decaying rate meter
// no dependencies
package drm_pkg;

	localparam int unsigned TICKS_PER_SEC = 7;
	localparam int unsigned USEC_PER_SEC = 1000000;
	localparam int unsigned MAX_DECAY_TICKS = 166;
	localparam logic [31:0] RATE_BIG = 32'h0FFF_FFFF;
	localparam int unsigned RATE_MAX_OUT = 32'd3758096377;

	localparam int unsigned AMT_W = 32;
	localparam int unsigned SEC_W = 32;
	localparam int unsigned USEC_W = 20;
	localparam int unsigned TOTAL_W = 64;
	localparam int unsigned RATE_W = 32;
	localparam int unsigned TICK_W = 32;
	localparam int unsigned CNT_W = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_PREP,
		ST_DECAY,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic calc_now;
		logic prep;
		logic step;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic decay_done;
	} dp_sts_t;

endpackage

// File: rtl/drm_datapath.sv
// datapath: word capture, tick conversion, decay step, totals and result register
// depends on drm_pkg
module drm_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  drm_pkg::dp_cmd_t               cmd,
	output drm_pkg::dp_sts_t               sts,
	input  logic [drm_pkg::AMT_W-1:0]      amount,
	input  logic [drm_pkg::SEC_W-1:0]      time_seconds,
	input  logic [drm_pkg::USEC_W-1:0]     time_microseconds,
	output logic [drm_pkg::TOTAL_W-1:0]    grand_total,
	output logic [drm_pkg::RATE_W-1:0]     rate_per_second
);

	logic [drm_pkg::AMT_W-1:0]   amt_q;
	logic [drm_pkg::SEC_W-1:0]   sec_q;
	logic [drm_pkg::USEC_W-1:0]  usec_q;
	logic [drm_pkg::TICK_W-1:0]  now_q;
	logic [drm_pkg::TICK_W-1:0]  last_q;
	logic [drm_pkg::RATE_W-1:0]  rate_q;
	logic [drm_pkg::RATE_W-1:0]  r_q;
	logic [drm_pkg::TOTAL_W-1:0] total_q;
	logic [drm_pkg::CNT_W-1:0]   cnt_q;
	logic                        long_q;
	logic [drm_pkg::TOTAL_W-1:0] total_out_q;
	logic [drm_pkg::RATE_W-1:0]  rate_out_q;

	logic [22:0]                 usec7;
	logic [2:0]                  frac;
	logic [drm_pkg::TICK_W-1:0]  sec7;
	logic [drm_pkg::TICK_W-1:0]  now_d;
	logic [drm_pkg::TICK_W-1:0]  diff;
	logic [drm_pkg::RATE_W-1:0]  r_plus7;
	logic [drm_pkg::RATE_W-1:0]  r_next;
	logic [drm_pkg::RATE_W-1:0]  new_rate;
	logic [drm_pkg::TOTAL_W-1:0] new_total;
	logic [drm_pkg::RATE_W-1:0]  q8;
	logic [drm_pkg::RATE_W-1:0]  per_sec;

	// microsecond fraction to ticks: count thresholds passed
	always_comb begin
		usec7 = ({3'b000, usec_q} << 3) - {3'b000, usec_q};
		frac = 3'd0;
		for (int k = 1; k <= int'(drm_pkg::TICKS_PER_SEC); k++) begin
			if (usec7 >= 23'(k * drm_pkg::USEC_PER_SEC)) begin
				frac = frac + 3'd1;
			end
		end
	end

	assign sec7 = (sec_q << 3) - sec_q;
	assign now_d = sec7 + {29'd0, frac};
	assign diff = now_q - last_q;

	assign r_plus7 = r_q + 32'd7;
	assign r_next = r_q - (r_plus7 >> 3);

	assign new_rate = long_q ? amt_q : r_q + amt_q;
	assign new_total = total_q + {32'd0, amt_q};

	always_comb begin
		q8 = new_rate >> 3;
		if (new_rate > drm_pkg::RATE_BIG) begin
			per_sec = (q8 << 3) - q8;
		end else begin
			per_sec = ((new_rate << 3) - new_rate + 32'd7) >> 3;
		end
	end

	assign sts.decay_done = long_q || (cnt_q == '0) || (r_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			amt_q <= amount;
			sec_q <= time_seconds;
			usec_q <= time_microseconds;
		end
		if (cmd.calc_now) begin
			now_q <= now_d;
		end
		if (cmd.prep) begin
			long_q <= diff > 32'(drm_pkg::MAX_DECAY_TICKS);
			cnt_q <= diff[drm_pkg::CNT_W-1:0];
			r_q <= rate_q;
		end else if (cmd.step) begin
			r_q <= r_next;
			cnt_q <= cnt_q - 8'd1;
		end
		if (cmd.commit) begin
			total_out_q <= new_total;
			rate_out_q <= per_sec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			rate_q <= '0;
			last_q <= '0;
		end else if (cmd.commit) begin
			total_q <= new_total;
			rate_q <= new_rate;
			last_q <= now_q;
		end
	end

	assign grand_total = total_out_q;
	assign rate_per_second = rate_out_q;

endmodule

// File: rtl/drm_ctrl.sv
// controller: sequences capture, tick conversion, decay loop and result hand-off
// depends on drm_pkg
module drm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output drm_pkg::dp_cmd_t cmd,
	input  drm_pkg::dp_sts_t sts
);

	drm_pkg::state_t state_q;
	drm_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			drm_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = drm_pkg::ST_TICK;
				end
			end
			drm_pkg::ST_TICK: begin
				cmd.calc_now = 1'b1;
				state_d = drm_pkg::ST_PREP;
			end
			drm_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = drm_pkg::ST_DECAY;
			end
			drm_pkg::ST_DECAY: begin
				if (sts.decay_done) begin
					state_d = drm_pkg::ST_COMMIT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			drm_pkg::ST_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d = drm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = drm_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != drm_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: rtl/decaying_rate_meter.sv
// steps: capture, tick conversion, decay setup, one decay step per tick, commit
// a new word is taken only after the commit of the previous one
// a finished result waits in the output register while the next word is taken
// reset: asynchronous active-low arst_n clears total, rate, last tick and control
// top level of the decaying rate meter, depends on drm_pkg, drm_ctrl, drm_datapath
module decaying_rate_meter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [drm_pkg::AMT_W-1:0]      amount,
	input  logic [drm_pkg::SEC_W-1:0]      time_seconds,
	input  logic [drm_pkg::USEC_W-1:0]     time_microseconds,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [drm_pkg::TOTAL_W-1:0]    grand_total,
	output logic [drm_pkg::RATE_W-1:0]     rate_per_second
);

	drm_pkg::dp_cmd_t cmd;
	drm_pkg::dp_sts_t sts;

	drm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	drm_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.amount            (amount),
		.time_seconds      (time_seconds),
		.time_microseconds (time_microseconds),
		.grand_total       (grand_total),
		.rate_per_second   (rate_per_second)
	);

`ifndef ASSERT_OFF
	// an accepted word keeps the meter busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("meter not busy after accept");

	// a new result appears only as the controller returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result without return to idle");

	// converted rate never exceeds the largest reachable value
	a_rate_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rate_per_second <= 32'(drm_pkg::RATE_MAX_OUT))
		else $error("rate out of range");

	// a commit never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid || !out_stall)
		else $error("result overwritten");
`endif

endmodule
